// ===== sv/necir_pkg.sv =====
`timescale 1ns / 1ps

package necir_pkg;

    // decoder phases; codes 6 and 7 are unused and fall back to idle
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MARK   = 3'd1,
        PH_SPACE  = 3'd2,
        PH_HIGH   = 3'd3,
        PH_LOW    = 3'd4,
        PH_REPEAT = 3'd5
    } t_phase;

    // configuration register indexes
    localparam logic [1:0] CFG_MARK_MIN  = 2'd0;
    localparam logic [1:0] CFG_SPACE_MIN = 2'd1;
    localparam logic [1:0] CFG_BIT_MIN   = 2'd2;
    localparam logic [1:0] CFG_BIT_MAX   = 2'd3;

    localparam int CFG_DATA_W = 12;

    // reset values of the limits
    localparam logic [11:0] MARK_MIN_RST  = 12'd787;
    localparam logic [10:0] SPACE_MIN_RST = 11'd219;
    localparam logic [6:0]  BIT_MIN_RST   = 7'd56;
    localparam logic [6:0]  BIT_MAX_RST   = 7'd84;

    // long gap marker in the interval
    localparam int GAP_BIT = 11;

    typedef struct packed {
        logic [11:0] mark_min;
        logic [10:0] space_min;
        logic [6:0]  bit_min;
        logic [6:0]  bit_max;
    } t_cfg;

    typedef struct packed {
        logic        frame_done;
        logic [31:0] frame_data;
        logic        repeat_seen;
        logic        timing_error;
    } t_result;

endpackage

// ===== sv/necir_step.sv =====
`timescale 1ns / 1ps

module necir_step #(
    parameter int FRAME_BITS = 32,
    parameter int CNT_W      = 6
) (
    input  necir_pkg::t_cfg    i_cfg,
    input  necir_pkg::t_phase  i_phase,
    input  logic [15:0]        i_last_time,
    input  logic [CNT_W-1:0]   i_bits,
    input  logic [31:0]        i_shift,
    input  logic [15:0]        i_edge_time,
    input  logic               i_line_active,
    output necir_pkg::t_phase  o_phase,
    output logic [CNT_W-1:0]   o_bits,
    output logic [31:0]        o_shift,
    output necir_pkg::t_result o_result
);
    import necir_pkg::*;

    logic [15:0] interval;
    logic [7:0]  lo8;
    t_phase      eff_phase;
    t_phase      phase_nx;
    logic [CNT_W-1:0] bits_nx;
    logic [31:0] shift_nx;
    logic        err;
    logic        rep;
    logic        done;
    logic        pulse_bad;
    logic [8:0]  bit_min3;
    logic [8:0]  bit_max3;
    logic [11:0] space_min2;

    // interval since the previous edge, wrapping with the timer
    assign interval   = i_edge_time - i_last_time;
    assign lo8        = interval[7:0];
    assign eff_phase  = interval[GAP_BIT] ? PH_IDLE : i_phase;

    // scaled limits
    assign bit_min3   = ({2'b00, i_cfg.bit_min} << 1) + {2'b00, i_cfg.bit_min};
    assign bit_max3   = ({2'b00, i_cfg.bit_max} << 1) + {2'b00, i_cfg.bit_max};
    assign space_min2 = {i_cfg.space_min, 1'b0};
    assign pulse_bad  = ({1'b0, lo8} < {2'b00, i_cfg.bit_min})
                     || ({1'b0, lo8} > {2'b00, i_cfg.bit_max});

    // phase walk for one edge
    always_comb begin
        phase_nx = PH_IDLE;
        bits_nx  = i_bits;
        shift_nx = i_shift;
        err      = 1'b0;
        rep      = 1'b0;
        unique case (eff_phase)
            PH_MARK: begin
                err      = interval < {4'b0000, i_cfg.mark_min};
                phase_nx = PH_SPACE;
            end
            PH_SPACE: begin
                err      = interval < {5'b00000, i_cfg.space_min};
                phase_nx = (interval < {4'b0000, space_min2}) ? PH_REPEAT : PH_HIGH;
            end
            PH_HIGH: begin
                err      = pulse_bad;
                phase_nx = PH_LOW;
            end
            PH_LOW: begin
                err      = ({1'b0, lo8} < {2'b00, i_cfg.bit_min})
                        || ({1'b0, lo8} > bit_max3);
                shift_nx = {({1'b0, lo8} >= bit_min3), i_shift[31:1]};
                bits_nx  = i_bits + CNT_W'(1);
                phase_nx = PH_HIGH;
            end
            PH_REPEAT: begin
                err      = pulse_bad;
                rep      = !pulse_bad;
                phase_nx = PH_IDLE;
            end
            default: begin
                phase_nx = i_line_active ? PH_MARK : PH_IDLE;
                bits_nx  = '0;
                shift_nx = '0;
            end
        endcase

        // an error drops the frame in progress
        if (err) begin
            phase_nx = PH_IDLE;
            bits_nx  = '0;
        end

        // frame complete
        done = (bits_nx == CNT_W'(FRAME_BITS));
        if (done) begin
            phase_nx = PH_IDLE;
            bits_nx  = '0;
        end
    end

    assign o_phase                 = phase_nx;
    assign o_bits                  = bits_nx;
    assign o_shift                 = shift_nx;
    assign o_result.frame_done     = done;
    assign o_result.frame_data     = done ? shift_nx : 32'd0;
    assign o_result.repeat_seen    = rep;
    assign o_result.timing_error   = err;

endmodule

// ===== sv/nec_ir_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// ch  | dir | valid / ready             | word fields
// ----+-----+---------------------------+-------------------------------------------------
// in  | in  | i_in_valid / o_in_ready   | edge_time, line_active
// out | out | o_out_valid / i_out_ready | frame_done, frame_data, repeat_seen, timing_error
// cfg | in  | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// one edge word per cycle sustained while the output is not stalled; a word is
// decoded from the input register and its result word is written into the result register
// the decoder state updates as a word moves from input register to result register
// a stalled output holds both registers full; the input takes a word whenever
// the input register is empty or moves on in the same cycle
// synchronous active-low reset clears state and valid flags and loads the reset limits

module nec_ir_frame_decoder_core #(
    parameter int FRAME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_edge_time,
    input  logic        i_line_active,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_done,
    output logic [31:0] o_frame_data,
    output logic        o_repeat_seen,
    output logic        o_timing_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [necir_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import necir_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    t_cfg       r_cfg;
    t_phase     r_phase;
    logic [15:0] r_last_time;
    logic [CNT_W-1:0] r_bits;
    logic [31:0] r_shift;

    logic        r_in_valid;
    logic [15:0] r_edge_time;
    logic        r_line_active;

    logic        r_out_valid;
    t_result     r_result;

    t_phase      n_phase;
    logic [CNT_W-1:0] n_bits;
    logic [31:0] n_shift;
    t_result     n_result;
    logic        advance;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mark_min  <= MARK_MIN_RST;
            r_cfg.space_min <= SPACE_MIN_RST;
            r_cfg.bit_min   <= BIT_MIN_RST;
            r_cfg.bit_max   <= BIT_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MARK_MIN:  r_cfg.mark_min  <= i_cfg_data;
                CFG_SPACE_MIN: r_cfg.space_min <= i_cfg_data[10:0];
                CFG_BIT_MIN:   r_cfg.bit_min   <= i_cfg_data[6:0];
                CFG_BIT_MAX:   r_cfg.bit_max   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // two-stage flow control
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_edge_time   <= i_edge_time;
            r_line_active <= i_line_active;
        end
    end

    // per-edge decision
    necir_step #(
        .FRAME_BITS (FRAME_BITS),
        .CNT_W      (CNT_W)
    ) u_step (
        .i_cfg         (r_cfg),
        .i_phase       (r_phase),
        .i_last_time   (r_last_time),
        .i_bits        (r_bits),
        .i_shift       (r_shift),
        .i_edge_time   (r_edge_time),
        .i_line_active (r_line_active),
        .o_phase       (n_phase),
        .o_bits        (n_bits),
        .o_shift       (n_shift),
        .o_result      (n_result)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_last_time <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_last_time <= r_edge_time;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_done   = r_result.frame_done;
    assign o_frame_data   = r_result.frame_data;
    assign o_repeat_seen  = r_result.repeat_seen;
    assign o_timing_error = r_result.timing_error;

    // checks
    a_done_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.frame_done && r_result.timing_error))
        else $error("frame reported together with timing error");

    a_rep_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.repeat_seen && r_result.timing_error))
        else $error("repeat reported together with timing error");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.frame_done) |-> (r_result.frame_data == 32'd0))
        else $error("frame data without frame");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits < CNT_W'(FRAME_BITS))
        else $error("bit count reached frame length in state");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("decoded word lost");

endmodule

// ===== bench/nec_ir_frame_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module nec_ir_frame_decoder_core_tb;
    import necir_pkg::*;

    localparam int FRAME_BITS      = 32;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 600;
    localparam int DIR_ITEMS       = 29;

    // predicted result words of the decoder, one per accepted edge word
    class ir_frame_scoreboard #(int FRAME_BITS = 32);
        t_cfg        lim;
        t_phase      phase;
        logic [15:0] last_stamp;
        logic [5:0]  bit_count;
        logic [31:0] shift_reg;
        t_result     expected_words[$];
        int          errors;
        int          checked;
        int          frames;
        int          repeats;
        int          flagged;

        function new();
            lim.mark_min  = MARK_MIN_RST;
            lim.space_min = SPACE_MIN_RST;
            lim.bit_min   = BIT_MIN_RST;
            lim.bit_max   = BIT_MAX_RST;
            phase      = PH_IDLE;
            last_stamp = '0;
            bit_count  = '0;
            shift_reg  = '0;
            errors     = 0;
            checked    = 0;
            frames     = 0;
            repeats    = 0;
            flagged    = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // limit register write, truncated to the register width
        function void set_limit(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MARK_MIN:  lim.mark_min  = data[11:0];
                CFG_SPACE_MIN: lim.space_min = data[10:0];
                CFG_BIT_MIN:   lim.bit_min   = data[6:0];
                CFG_BIT_MAX:   lim.bit_max   = data[6:0];
                default: ;
            endcase
        endfunction

        // walk the phase machine for one accepted edge word
        function void note_edge(logic [15:0] stamp, logic active);
            logic [15:0] gap;
            int unsigned span;
            int unsigned lo8;
            int unsigned mark_min;
            int unsigned space_min;
            int unsigned bmin;
            int unsigned bmax;
            t_result     word;
            gap       = stamp - last_stamp;
            span      = 32'(gap);
            lo8       = 32'(gap[7:0]);
            mark_min  = 32'(lim.mark_min);
            space_min = 32'(lim.space_min);
            bmin      = 32'(lim.bit_min);
            bmax      = 32'(lim.bit_max);
            word      = '0;
            last_stamp = stamp;
            // a long gap restarts the machine
            if (gap[GAP_BIT]) phase = PH_IDLE;
            case (phase)
                PH_MARK: begin
                    if (span < mark_min) word.timing_error = 1'b1;
                    phase = PH_SPACE;
                end
                PH_SPACE: begin
                    if (span < space_min) word.timing_error = 1'b1;
                    phase = (span < 2 * space_min) ? PH_REPEAT : PH_HIGH;
                end
                PH_HIGH: begin
                    if (lo8 < bmin || lo8 > bmax) word.timing_error = 1'b1;
                    phase = PH_LOW;
                end
                PH_LOW: begin
                    if (lo8 < bmin || lo8 > 3 * bmax) word.timing_error = 1'b1;
                    shift_reg = {(lo8 >= 3 * bmin), shift_reg[31:1]};
                    bit_count = bit_count + 6'd1;
                    phase = PH_HIGH;
                end
                PH_REPEAT: begin
                    if (lo8 < bmin || lo8 > bmax) word.timing_error = 1'b1;
                    else word.repeat_seen = 1'b1;
                    phase = PH_IDLE;
                end
                default: begin
                    phase = active ? PH_MARK : PH_IDLE;
                    bit_count = '0;
                    shift_reg = '0;
                end
            endcase
            // an error drops the frame in progress but keeps the shift register
            if (word.timing_error) begin
                phase = PH_IDLE;
                bit_count = '0;
            end
            if (bit_count == FRAME_BITS) begin
                word.frame_done = 1'b1;
                word.frame_data = shift_reg;
                phase = PH_IDLE;
                bit_count = '0;
            end
            frames  += int'(word.frame_done);
            repeats += int'(word.repeat_seen);
            flagged += int'(word.timing_error);
            expected_words.push_back(word);
        endfunction

        // compare one result word with the oldest prediction
        function void check_word(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                $error("result word with no edge word pending");
                errors++;
                return;
            end
            want = expected_words.pop_front();
            checked++;
            if (got.frame_done !== want.frame_done) begin
                $error("frame_done expected %0b actual %0b", want.frame_done,
                       got.frame_done);
                errors++;
            end
            if (got.frame_data !== want.frame_data) begin
                $error("frame_data expected %08h actual %08h", want.frame_data,
                       got.frame_data);
                errors++;
            end
            if (got.repeat_seen !== want.repeat_seen) begin
                $error("repeat_seen expected %0b actual %0b", want.repeat_seen,
                       got.repeat_seen);
                errors++;
            end
            if (got.timing_error !== want.timing_error) begin
                $error("timing_error expected %0b actual %0b", want.timing_error,
                       got.timing_error);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [15:0]           i_edge_time   = '0;
    logic                  i_line_active = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic                  o_frame_done;
    logic [31:0]           o_frame_data;
    logic                  o_repeat_seen;
    logic                  o_timing_error;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    ir_frame_scoreboard #(FRAME_BITS) sb;
    logic [15:0] stamp_now = '0;
    int          sent      = 0;
    int          settings  = 1;
    int          idle_pct  = 25;

    // directed edges as intervals from the previous edge
    logic [15:0] dir_gap [DIR_ITEMS] = '{
        16'd0,    16'hFFFF, 16'd1125, 16'd281,  16'd70,
        16'h0800, 16'd786,  16'h0FFF, 16'd1125, 16'd200,
        16'h0800, 16'd1125, 16'd562,  16'd55,
        16'h0800, 16'd1125, 16'd562,  16'h7054, 16'd253,
        16'h0800, 16'd787,  16'd438,  16'd56,   16'd168,  16'd85,
        16'h0800, 16'd1125, 16'd437,  16'd85
    };
    logic dir_act [DIR_ITEMS] = '{
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0, 1'b0, 1'b1
    };

    nec_ir_frame_decoder_core #(
        .FRAME_BITS(FRAME_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_edge_time    (i_edge_time),
        .i_line_active  (i_line_active),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_done   (o_frame_done),
        .o_frame_data   (o_frame_data),
        .o_repeat_seen  (o_repeat_seen),
        .o_timing_error (o_timing_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("nec_ir_frame_decoder_core_tb: errors");
        $finish;
    end

    // handshake monitor: limit writes, edge words, result words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_limit(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_edge(i_edge_time, i_line_active);
            if (o_out_valid && i_out_ready)
                sb.check_word({o_frame_done, o_frame_data, o_repeat_seen, o_timing_error});
        end
    end

    // result side: random stalls, one long hold-off while edges keep coming
    initial begin : rx_side
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99, 0) >= idle_pct);
        end
    end

    // offer one edge word and wait until it is taken
    task automatic send_edge(input logic [15:0] stamp, input logic active);
        if ($urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_edge_time   <= stamp;
        i_line_active <= active;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    task automatic push_gap(input logic [15:0] gap, input logic active);
        stamp_now = stamp_now + gap;
        send_edge(stamp_now, active);
    endtask

    // interval with the long gap bit set
    function automatic logic [15:0] long_gap();
        return 16'($urandom()) | 16'h0800;
    endfunction

    // interval of at least lo, kept clear of the long gap bit
    function automatic logic [15:0] wide_gap(input int unsigned lo, input int unsigned span);
        int unsigned v;
        v = lo + $urandom_range(span, 0);
        if (v & 32'h0800) v += 32'h0800;
        return v[15:0];
    endfunction

    // pulse interval: low byte in [lo, hi] (any byte if lo > hi), random upper bits now and then
    function automatic logic [15:0] pulse_gap(input int lo, input int hi);
        int unsigned lo8;
        int unsigned upper;
        if (hi > 255) hi = 255;
        lo8   = (lo > hi) ? $urandom_range(255, 0) : $urandom_range(hi, lo);
        upper = ($urandom_range(3, 0) == 0) ? ($urandom() & 32'h0000_F700) : 0;
        return 16'(upper | lo8);
    endfunction

    // leader and data bits; a cut below FRAME_BITS breaks the frame there
    task automatic send_frame(input int cut);
        int  bmin;
        int  bmax;
        logic one;
        bmin = int'(sb.lim.bit_min);
        bmax = int'(sb.lim.bit_max);
        push_gap(long_gap(), 1'b1);
        push_gap(wide_gap(32'(sb.lim.mark_min), 300), 1'($urandom_range(1, 0)));
        push_gap(wide_gap(2 * 32'(sb.lim.space_min), 200), 1'($urandom_range(1, 0)));
        for (int i = 0; i < FRAME_BITS; i++) begin
            if (i == cut) begin
                push_gap(16'($urandom()), 1'($urandom_range(1, 0)));
                return;
            end
            push_gap(pulse_gap(bmin, bmax), 1'($urandom_range(1, 0)));
            one = 1'($urandom_range(1, 0));
            push_gap(one ? pulse_gap(3 * bmin, 3 * bmax) : pulse_gap(bmin, 3 * bmin - 1),
                     1'($urandom_range(1, 0)));
        end
    endtask

    // leader with short space and a burst
    task automatic send_repeat();
        int unsigned s;
        s = 32'(sb.lim.space_min);
        push_gap(long_gap(), 1'b1);
        push_gap(wide_gap(32'(sb.lim.mark_min), 300), 1'($urandom_range(1, 0)));
        push_gap(wide_gap(s, (s > 0) ? s - 1 : 0), 1'($urandom_range(1, 0)));
        push_gap(pulse_gap(int'(sb.lim.bit_min), int'(sb.lim.bit_max)),
                 1'($urandom_range(1, 0)));
    endtask

    // line noise
    task automatic send_noise();
        int n;
        n = $urandom_range(8, 1);
        repeat (n) begin
            case ($urandom_range(2, 0))
                0:       push_gap(16'($urandom()), 1'($urandom_range(1, 0)));
                1:       push_gap(pulse_gap(0, 255), 1'($urandom_range(1, 0)));
                default: push_gap(long_gap(), 1'($urandom_range(1, 0)));
            endcase
        end
    endtask

    task automatic run_phase(input int n_items);
        int target;
        int pick;
        target = sent + n_items;
        while (sent < target) begin
            pick = $urandom_range(99, 0);
            if (pick < 55)      send_frame(FRAME_BITS);
            else if (pick < 70) send_repeat();
            else if (pick < 85) send_frame($urandom_range(FRAME_BITS - 1, 0));
            else                send_noise();
        end
    endtask

    // stop offering and wait until every result word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_limits(input logic [CFG_DATA_W-1:0] mark,
                                input logic [CFG_DATA_W-1:0] space,
                                input logic [CFG_DATA_W-1:0] bmin,
                                input logic [CFG_DATA_W-1:0] bmax);
        write_reg(CFG_MARK_MIN, mark);
        write_reg(CFG_SPACE_MIN, space);
        write_reg(CFG_BIT_MIN, bmin);
        write_reg(CFG_BIT_MAX, bmax);
        i_cfg_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        settings++;
    endtask

    // stimulus
    initial begin
        int bmin;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed edges under the reset limits
        for (int k = 0; k < DIR_ITEMS; k++) push_gap(dir_gap[k], dir_act[k]);
        drain();
        run_phase(ITEMS_PER_PHASE);
        drain();

        // all limits at zero
        apply_limits('0, '0, '0, '0);
        run_phase(ITEMS_PER_PHASE);
        drain();

        // mark and space limits at the top of their range, both bit limits at 85
        apply_limits(12'd4095, 12'd2047, 12'd85, 12'd85);
        run_phase(ITEMS_PER_PHASE);
        drain();

        // typical timing, no idling on either side
        idle_pct = 0;
        bmin = $urandom_range(60, 40);
        apply_limits(CFG_DATA_W'($urandom_range(1100, 600)),
                     CFG_DATA_W'($urandom_range(280, 150)), CFG_DATA_W'(bmin),
                     CFG_DATA_W'($urandom_range(85, bmin)));
        run_phase(ITEMS_PER_PHASE);
        drain();
        idle_pct = 25;

        // raw data words, upper bits dropped by the register widths
        apply_limits(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                     CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        run_phase(ITEMS_PER_PHASE);
        drain();

        // anywhere within range, bit limits up to 85
        apply_limits(CFG_DATA_W'($urandom_range(4095, 0)),
                     CFG_DATA_W'($urandom_range(2047, 0)),
                     CFG_DATA_W'($urandom_range(85, 0)),
                     CFG_DATA_W'($urandom_range(85, 0)));
        run_phase(ITEMS_PER_PHASE);
        drain();

        // back to the reset limits
        apply_limits(CFG_DATA_W'(MARK_MIN_RST), CFG_DATA_W'(SPACE_MIN_RST),
                     CFG_DATA_W'(BIT_MIN_RST), CFG_DATA_W'(BIT_MAX_RST));
        run_phase(ITEMS_PER_PHASE);
        drain();

        $display("covered %0d edge words under %0d limit settings", sent, settings);
        $display("%0d frames, %0d repeats, %0d timing errors predicted; %0d words checked",
                 sb.frames, sb.repeats, sb.flagged, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("nec_ir_frame_decoder_core_tb: clean");
        end else begin
            $display("nec_ir_frame_decoder_core_tb: errors");
        end
        $finish;
    end
endmodule
